@@ rtl/s2id_pkg.sv @@
// Shared types and constants of the SECS-II data item stream decoder.
package s2id_pkg;

	localparam int unsigned LenW  = 24;
	localparam int unsigned ValW  = 32;
	localparam int unsigned FmtW  = 6;
	localparam int unsigned TdataW = 72;

	localparam logic [1:0]      LEN_COUNT_MASK = 2'h3;
	localparam logic [LenW-1:0] LEN_MAX        = 24'd16777215;

	// Format codes
	localparam logic [FmtW-1:0] F_LIST  = 6'd0;
	localparam logic [FmtW-1:0] F_BIN   = 6'd8;
	localparam logic [FmtW-1:0] F_BOOL  = 6'd9;
	localparam logic [FmtW-1:0] F_ASCII = 6'd16;
	localparam logic [FmtW-1:0] F_U1    = 6'd41;
	localparam logic [FmtW-1:0] F_U2    = 6'd42;
	localparam logic [FmtW-1:0] F_U4    = 6'd44;

	// Result kinds
	localparam logic [1:0] K_HEADER = 2'd0;
	localparam logic [1:0] K_BYTE   = 2'd1;
	localparam logic [1:0] K_VALUE  = 2'd2;
	localparam logic [1:0] K_ERROR  = 2'd3;

	// Error codes
	localparam logic [2:0] E_BAD_COUNT  = 3'd0;
	localparam logic [2:0] E_UNKNOWN    = 3'd1;
	localparam logic [2:0] E_UNEXPECTED = 3'd2;
	localparam logic [2:0] E_INT_LENGTH = 3'd3;
	localparam logic [2:0] E_TRUNCATED  = 3'd4;

	// Configuration register indexes
	localparam logic CFG_CHECK_FORMAT    = 1'b0;
	localparam logic CFG_EXPECTED_FORMAT = 1'b1;

	typedef struct packed {
		logic            check_format;
		logic [FmtW-1:0] expected_format;
	} cfg_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [FmtW-1:0] item_format;
		logic [LenW-1:0] body_length;
		logic [ValW-1:0] value;
		logic            is_null;
		logic [2:0]      err_code;
		logic            item_done;
	} res_t;

	// Body size of an unsigned integer format, zero for any other format.
	function automatic logic [2:0] int_size(input logic [FmtW-1:0] f);
		logic [2:0] sz;
		sz = 3'd0;
		if (f == F_U1) sz = 3'd1;
		else if (f == F_U2) sz = 3'd2;
		else if (f == F_U4) sz = 3'd4;
		return sz;
	endfunction

endpackage

@@ rtl/secs2_item_stream_decoder_unit.sv @@
// Top level of the SECS-II data item stream decoder.
// Each result is registered in the output stage before the master side sees it.
// Throughput: one byte per cycle; s_axis_tready falls only while two results wait.
// Sound format and leading length bytes, and dropped bytes, give no result.
// Reset clears the parse state, both result entries and the configuration registers.
module secs2_item_stream_decoder_unit import s2id_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
	input  logic              s_axis_tlast,   // end_of_buffer
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [5:0] item_format, [29:6] body_length, [61:30] value, [62] is_null,
	// [65:63] err_code, [71:66] zero
	output logic [TdataW-1:0] m_axis_tdata,
	output logic [1:0]        m_axis_tuser,   // [1:0] kind
	output logic              m_axis_tlast,   // item_done
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [FmtW-1:0]   cfg_data
);

	cfg_t cfg_q;
	logic in_accept;
	logic res_valid;
	res_t res;
	res_t out_res;

	assign cfg_ready = 1'b1;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHECK_FORMAT:    cfg_q.check_format <= cfg_data[0];
				CFG_EXPECTED_FORMAT: cfg_q.expected_format <= cfg_data;
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	s2id_decoder u_decoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_accept     (in_accept),
		.in_byte       (s_axis_tdata),
		.end_of_buffer (s_axis_tlast),
		.cfg           (cfg_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	s2id_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_res   (res),
		.push_ready (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = {6'b0, out_res.err_code, out_res.is_null, out_res.value,
		out_res.body_length, out_res.item_format};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.item_done;

endmodule

@@ rtl/s2id_decoder.sv @@
// Byte-at-a-time item parser: holds the decode state and forms at most one result per byte.
module s2id_decoder import s2id_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_buffer,
	input  cfg_t       cfg,
	output logic       res_valid,
	output res_t       res
);

	typedef enum logic [1:0] {PH_FORMAT, PH_LENGTH, PH_BODY, PH_DROP} phase_t;

	phase_t          phase_q, phase_d;
	logic [FmtW-1:0] fmt_q, fmt_d;
	logic [1:0]      len_left_q, len_left_d;
	logic [LenW-1:0] len_acc_q, len_acc_d;
	logic [LenW-1:0] body_left_q, body_left_d;
	logic [ValW-1:0] val_q, val_d;
	logic            produce;

	logic [LenW-1:0] len_new;
	logic [2:0]      sz;
	logic            known;
	logic            fail_phase_drop;

	assign len_new = {len_acc_q[LenW-9:0], in_byte};
	assign sz      = int_size(fmt_q);
	assign known   = (fmt_q == F_BIN) || (fmt_q == F_BOOL) || (fmt_q == F_ASCII) || (sz != 3'd0);
	assign fail_phase_drop = !end_of_buffer;

	always_comb begin
		phase_d     = phase_q;
		fmt_d       = fmt_q;
		len_left_d  = len_left_q;
		len_acc_d   = len_acc_q;
		body_left_d = body_left_q;
		val_d       = val_q;
		produce     = 1'b0;
		res         = '0;
		res.item_format = fmt_q;
		case (phase_q)
			PH_FORMAT: begin
				fmt_d       = in_byte[7:2];
				len_acc_d   = '0;
				body_left_d = '0;
				val_d       = '0;
				len_left_d  = in_byte[1:0] & LEN_COUNT_MASK;
				res.item_format = in_byte[7:2];
				if ((in_byte[1:0] & LEN_COUNT_MASK) == 2'd0) begin
					produce = 1'b1;
					res.kind = K_ERROR;
					res.err_code = E_BAD_COUNT;
					res.item_done = 1'b1;
					phase_d = fail_phase_drop ? PH_DROP : PH_FORMAT;
				end else if (end_of_buffer) begin
					produce = 1'b1;
					res.kind = K_ERROR;
					res.err_code = E_TRUNCATED;
					res.item_done = 1'b1;
					phase_d = PH_FORMAT;
				end else begin
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				len_acc_d  = len_new & LEN_MAX;
				len_left_d = len_left_q - 2'd1;
				if (len_left_q == 2'd1) begin
					// Length complete: checks run in a fixed order.
					produce = 1'b1;
					res.body_length = len_new;
					res.item_done = 1'b1;
					if (cfg.check_format && (fmt_q != cfg.expected_format)) begin
						res.kind = K_ERROR;
						res.err_code = E_UNEXPECTED;
						phase_d = fail_phase_drop ? PH_DROP : PH_FORMAT;
					end else if (fmt_q == F_LIST) begin
						res.kind = K_HEADER;
						phase_d = PH_FORMAT;
					end else if (known) begin
						if (len_new == '0) begin
							res.kind = K_HEADER;
							res.is_null = (sz != 3'd0);
							phase_d = PH_FORMAT;
						end else if ((sz != 3'd0) && (len_new != {{(LenW-3){1'b0}}, sz})) begin
							res.kind = K_ERROR;
							res.err_code = E_INT_LENGTH;
							phase_d = fail_phase_drop ? PH_DROP : PH_FORMAT;
						end else if (end_of_buffer) begin
							res.kind = K_ERROR;
							res.err_code = E_TRUNCATED;
							phase_d = PH_FORMAT;
						end else begin
							res.kind = K_HEADER;
							res.item_done = 1'b0;
							body_left_d = len_new;
							val_d = '0;
							phase_d = PH_BODY;
						end
					end else begin
						res.kind = K_ERROR;
						res.err_code = E_UNKNOWN;
						phase_d = fail_phase_drop ? PH_DROP : PH_FORMAT;
					end
				end else if (end_of_buffer) begin
					produce = 1'b1;
					res.kind = K_ERROR;
					res.err_code = E_TRUNCATED;
					res.item_done = 1'b1;
					phase_d = PH_FORMAT;
				end
			end
			PH_BODY: begin
				body_left_d = body_left_q - 24'd1;
				res.body_length = len_acc_q;
				if (sz != 3'd0) begin
					val_d = {val_q[ValW-9:0], in_byte};
					if (body_left_q == 24'd1) begin
						produce = 1'b1;
						res.kind = K_VALUE;
						res.value = {val_q[ValW-9:0], in_byte};
						res.item_done = 1'b1;
						phase_d = PH_FORMAT;
					end else if (end_of_buffer) begin
						produce = 1'b1;
						res.kind = K_ERROR;
						res.err_code = E_TRUNCATED;
						res.item_done = 1'b1;
						phase_d = PH_FORMAT;
					end
				end else begin
					produce = 1'b1;
					if (body_left_q == 24'd1) begin
						res.kind = K_BYTE;
						res.value = {{(ValW-8){1'b0}}, in_byte};
						res.item_done = 1'b1;
						phase_d = PH_FORMAT;
					end else if (end_of_buffer) begin
						res.kind = K_ERROR;
						res.err_code = E_TRUNCATED;
						res.item_done = 1'b1;
						phase_d = PH_FORMAT;
					end else begin
						res.kind = K_BYTE;
						res.value = {{(ValW-8){1'b0}}, in_byte};
					end
				end
			end
			PH_DROP: begin
				if (end_of_buffer) begin
					phase_d = PH_FORMAT;
				end
			end
			default: begin
				phase_d = PH_FORMAT;
			end
		endcase
	end

	assign res_valid = in_accept && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FORMAT;
			fmt_q       <= '0;
			len_left_q  <= '0;
			len_acc_q   <= '0;
			body_left_q <= '0;
			val_q       <= '0;
		end else if (in_accept) begin
			phase_q     <= phase_d;
			fmt_q       <= fmt_d;
			len_left_q  <= len_left_d;
			len_acc_q   <= len_acc_d;
			body_left_q <= body_left_d;
			val_q       <= val_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_body_owed: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> body_left_q != '0)
		else $error("body phase with no bytes owed");
	a_len_owed: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LENGTH |-> len_left_q != 2'd0)
		else $error("length phase with no length bytes owed");
	a_err_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == K_ERROR |=> phase_q == PH_FORMAT || phase_q == PH_DROP)
		else $error("error did not end the item");
	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.item_done && res.kind != K_ERROR |=> phase_q == PH_FORMAT)
		else $error("finished item did not return to the format byte");
`endif

endmodule

@@ rtl/s2id_out_stage.sv @@
// Result register with a skid entry, so the parser keeps taking bytes while a result waits.
module s2id_out_stage import s2id_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic push_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic main_free;

	assign main_free  = !main_valid_q || out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_res    = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry holds a result while the output register is empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed while both entries are full");
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(main_valid_q && !out_ready && push))
		else $error("skid entry filled without a stalled output");
`endif

endmodule
